>>> rtl/hkps_pkg.sv
// Shared types, constants and the control program for the HID to PS/2 scancode unit.
// Holds the set-2 key map and the microcode table; depends on nothing.
package hkps_pkg;

  localparam logic [7:0] SC_SHIFT  = 8'h12;
  localparam logic [7:0] SC_EXT    = 8'hE0;
  localparam logic [7:0] SC_BREAK  = 8'hF0;
  localparam logic [7:0] SC_DELETE = 8'h71;
  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;  // left and right shift modifier bits

  localparam int MAX_OUT = 33;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // configuration register indexes (paddr[2])
  localparam logic REG_REPEAT_DELAY = 1'b0;
  localparam logic REG_REPEAT_IVL   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLOT_RD, ST_SLOT_SH, ST_SLOT_E0, ST_SLOT_CD,
    ST_SCAN_RD, ST_SCAN_TS, ST_SCAN_E0, ST_SCAN_F0, ST_SCAN_CD,
    ST_SH_F0, ST_SH_12, ST_FLUSH, ST_CLEAR
  } step_t;

  typedef enum logic [2:0] {
    K_IDLE, K_CLEAR, K_SLOT_RD, K_EMIT, K_SCAN_RD, K_SCAN_TEST, K_FLUSH
  } kind_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_SHIFT_MAKE, C_DEL_HIT, C_HIT, C_REL_DEL, C_SHIFT_BRK
  } cond_t;

  typedef enum logic [2:0] {
    B_SHIFT, B_EXT, B_BREAK, B_SLOT_CODE, B_SCAN_CODE
  } bsel_t;

  typedef struct packed {
    kind_t kind;
    cond_t cond;
    bsel_t bsel;
    logic  wr_inc;
    logic  wr_zero;
    logic  set_make;
    logic  clr_make;
    logic  adv_slot;
    logic  adv_scan;
    step_t nxt;
    step_t alt;   // taken at the end of a loop
  } uword_t;

  typedef struct packed {
    logic       push;
    logic       flush;
    logic [7:0] data;
  } emit_ctl_t;

  function automatic logic [7:0] set2_map(logic [7:0] k);
    logic [7:0] c;
    case (k)
      8'h04: c = 8'h1C; 8'h05: c = 8'h32; 8'h06: c = 8'h21; 8'h07: c = 8'h23;
      8'h08: c = 8'h24; 8'h09: c = 8'h2B; 8'h0A: c = 8'h34; 8'h0B: c = 8'h33;
      8'h0C: c = 8'h43; 8'h0D: c = 8'h3B; 8'h0E: c = 8'h42; 8'h0F: c = 8'h4B;
      8'h10: c = 8'h3A; 8'h11: c = 8'h31; 8'h12: c = 8'h44; 8'h13: c = 8'h4D;
      8'h14: c = 8'h15; 8'h15: c = 8'h2D; 8'h16: c = 8'h1B; 8'h17: c = 8'h2C;
      8'h18: c = 8'h3C; 8'h19: c = 8'h2A; 8'h1A: c = 8'h1D; 8'h1B: c = 8'h22;
      8'h1C: c = 8'h35; 8'h1D: c = 8'h1A;
      8'h1E: c = 8'h16; 8'h1F: c = 8'h1E; 8'h20: c = 8'h26; 8'h21: c = 8'h25;
      8'h22: c = 8'h2E; 8'h23: c = 8'h36; 8'h24: c = 8'h3D; 8'h25: c = 8'h3E;
      8'h26: c = 8'h46; 8'h27: c = 8'h45;
      8'h28: c = 8'h5A; 8'h29: c = 8'h76; 8'h2A: c = 8'h66; 8'h2B: c = 8'h0D;
      8'h2C: c = 8'h29; 8'h2D: c = 8'h4E; 8'h2E: c = 8'h55; 8'h2F: c = 8'h54;
      8'h30: c = 8'h5B; 8'h31: c = 8'h5D; 8'h33: c = 8'h4C; 8'h34: c = 8'h52;
      8'h35: c = 8'h0E; 8'h36: c = 8'h41; 8'h37: c = 8'h49; 8'h38: c = 8'h4A;
      8'h3A: c = 8'h05; 8'h3B: c = 8'h06; 8'h3C: c = 8'h04; 8'h3D: c = 8'h0C;
      8'h3E: c = 8'h03; 8'h3F: c = 8'h0B; 8'h40: c = 8'h83; 8'h41: c = 8'h0A;
      8'h42: c = 8'h01; 8'h43: c = 8'h09; 8'h44: c = 8'h78; 8'h45: c = 8'h07;
      8'h4C: c = 8'h71;
      8'h4F: c = 8'h74; 8'h50: c = 8'h6B; 8'h51: c = 8'h72; 8'h52: c = 8'h75;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // control program: one word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w.kind = K_IDLE;  w.cond = C_ALWAYS; w.bsel = B_SHIFT;
    w.wr_inc = 1'b0;  w.wr_zero = 1'b0;  w.set_make = 1'b0; w.clr_make = 1'b0;
    w.adv_slot = 1'b0; w.adv_scan = 1'b0;
    w.nxt = ST_IDLE;  w.alt = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.nxt = ST_SLOT_RD;
      end
      ST_CLEAR: begin
        w.kind = K_CLEAR; w.alt = ST_IDLE;
      end
      ST_SLOT_RD: begin
        w.kind = K_SLOT_RD; w.nxt = ST_SLOT_SH; w.alt = ST_SCAN_RD;
      end
      ST_SLOT_SH: begin
        w.kind = K_EMIT; w.cond = C_SHIFT_MAKE; w.bsel = B_SHIFT;
        w.set_make = 1'b1; w.wr_inc = 1'b1; w.nxt = ST_SLOT_E0;
      end
      ST_SLOT_E0: begin
        w.kind = K_EMIT; w.cond = C_DEL_HIT; w.bsel = B_EXT; w.nxt = ST_SLOT_CD;
      end
      ST_SLOT_CD: begin
        w.kind = K_EMIT; w.cond = C_HIT; w.bsel = B_SLOT_CODE; w.adv_slot = 1'b1;
        w.nxt = ST_SLOT_RD; w.alt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        w.kind = K_SCAN_RD; w.nxt = ST_SCAN_TS;
      end
      ST_SCAN_TS: begin
        w.kind = K_SCAN_TEST; w.nxt = ST_SCAN_E0; w.alt = ST_SH_F0;
      end
      ST_SCAN_E0: begin
        w.kind = K_EMIT; w.cond = C_REL_DEL; w.bsel = B_EXT; w.nxt = ST_SCAN_F0;
      end
      ST_SCAN_F0: begin
        w.kind = K_EMIT; w.bsel = B_BREAK; w.wr_zero = 1'b1; w.nxt = ST_SCAN_CD;
      end
      ST_SCAN_CD: begin
        w.kind = K_EMIT; w.bsel = B_SCAN_CODE; w.adv_scan = 1'b1;
        w.nxt = ST_SCAN_RD; w.alt = ST_SH_F0;
      end
      ST_SH_F0: begin
        w.kind = K_EMIT; w.cond = C_SHIFT_BRK; w.bsel = B_BREAK; w.nxt = ST_SH_12;
      end
      ST_SH_12: begin
        w.kind = K_EMIT; w.cond = C_SHIFT_BRK; w.bsel = B_SHIFT; w.clr_make = 1'b1;
        w.nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        w.kind = K_FLUSH; w.nxt = ST_IDLE;
      end
      default: begin
        w.kind = K_IDLE; w.nxt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/hkps_emit.sv
// Output stage: one pending byte plus the output register, byte cap and last flag.
// Depends on hkps_pkg for emit_ctl_t, MAX_OUT and CNT_W.
module hkps_emit import hkps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  emit_ctl_t  ctl,
  input  logic       out_stall,
  output logic       hold,
  output logic       out_valid,
  output logic [7:0] out_scancode,
  output logic       out_last
);

  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic             can_push, push_eff, move;

  assign can_push = !ov_r || !out_stall;
  // drop bytes once the per-tick cap is reached; the pending byte stays the final one
  assign push_eff = ctl.push && (n_r < CNT_W'(MAX_OUT));
  assign move     = pend_v_r && (push_eff || ctl.flush);
  assign hold     = move && !can_push;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    n_nxt      = n_r;
    ov_nxt     = ov_r;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (move && can_push) begin
      ov_nxt = 1'b1;
      ob_nxt = pend_r;
      ol_nxt = ctl.flush;
    end
    if (!hold) begin
      if (push_eff) begin
        pend_nxt   = ctl.data;
        pend_v_nxt = 1'b1;
        n_nxt      = n_r + CNT_W'(1);
      end else if (ctl.flush) begin
        pend_v_nxt = 1'b0;
        n_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      n_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid    = ov_r;
  assign out_scancode = ob_r;
  assign out_last     = ol_r;

endmodule

>>> rtl/hid_keys_to_ps2_scancodes_unit.sv
// Top level of the HID report to PS/2 set-2 scancode unit: microcoded sequencer,
// hold-counter memory and configuration registers. Depends on hkps_pkg and hkps_emit.
//
//   channel | direction | transfer when          | payload
//   in_     | input     | in_valid & !in_stall   | op, report_length, byte0..byte7
//   out_    | output    | out_valid & !out_stall | scancode, last
//   cfg     | APB write | psel&penable&pwrite    | repeat_delay, repeat_interval_log2
//
// A report is taken at the idle step and leaves the sequencer idle.
// A tick's length is set by the walk of the hold-counter memory (one read port and
// one write port), plus any time lost to out_stall with the output register full.
// After reset a clearing pass zeroes every memory entry; in_stall stays high.
// in_stall is high whenever the sequencer is not at its idle step.
module hid_keys_to_ps2_scancodes_unit import hkps_pkg::*; #(
  parameter int KEY_SLOTS = 6,
  parameter int KEY_CODES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [3:0]  in_report_length,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [7:0]  in_byte6,
  input  logic [7:0]  in_byte7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_scancode,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CW = $clog2(KEY_CODES);

  step_t             step_r, step_nxt;
  uword_t            cw;
  logic [7:0]        held_r [KEY_SLOTS];
  logic [7:0]        held_nxt [KEY_SLOTS];
  logic              shift_down_r, shift_down_nxt;
  logic              make_sent_r, make_sent_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              key_held;
  logic [7:0]        delay_r;
  logic [2:0]        ivl_r;

  logic [7:0]        mem [KEY_CODES];
  logic [7:0]        rd_q_r;
  logic              rd_en, wr_en;
  logic [CW-1:0]     rd_addr, wr_addr;
  logic [7:0]        wr_data;

  logic [7:0]        rpt [8];
  logic              in_acc, slot_last, scan_last;
  logic [7:0]        key, code_slot, code_scan, cnt, mask, diff;
  logic              is_new, rep, hit, release_k, cond_ok, go, hold;
  emit_ctl_t         ectl;
  logic              cfg_wr;

  assign rpt[0] = in_byte0; assign rpt[1] = in_byte1;
  assign rpt[2] = in_byte2; assign rpt[3] = in_byte3;
  assign rpt[4] = in_byte4; assign rpt[5] = in_byte5;
  assign rpt[6] = in_byte6; assign rpt[7] = in_byte7;

  assign cw        = ucode(step_r);
  assign in_stall  = (step_r != ST_IDLE);
  assign in_acc    = in_valid && (step_r == ST_IDLE);
  assign slot_last = (slot_r == SW'(KEY_SLOTS - 1));
  assign scan_last = (j_r == CW'(KEY_CODES - 1));

  assign key       = held_r[slot_r];
  assign code_slot = set2_map(key);
  assign code_scan = set2_map(8'(j_r));
  assign cnt       = rd_q_r;
  assign mask      = 8'((8'd1 << ivl_r) - 8'd1);
  assign diff      = cnt - delay_r;
  assign is_new    = (cnt == 8'd0);
  assign rep       = !is_new && ((cnt == delay_r) ||
                     ((cnt > delay_r) && ((diff & mask) == 8'd0)));
  assign hit       = is_new || rep;
  assign release_k = !key_held && !is_new;

  // held keys stay fixed for the whole tick, so compare the scan index against the slots
  always_comb begin
    key_held = 1'b0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (held_r[s] == 8'(j_r)) key_held = 1'b1;
    end
  end

  always_comb begin
    case (cw.cond)
      C_ALWAYS:     cond_ok = 1'b1;
      C_SHIFT_MAKE: cond_ok = is_new && shift_down_r && !make_sent_r;
      C_DEL_HIT:    cond_ok = hit && (code_slot == SC_DELETE);
      C_HIT:        cond_ok = hit;
      C_REL_DEL:    cond_ok = (code_scan == SC_DELETE);
      C_SHIFT_BRK:  cond_ok = !shift_down_r && make_sent_r;
      default:      cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    ectl.push  = (cw.kind == K_EMIT) && cond_ok;
    ectl.flush = (cw.kind == K_FLUSH);
    case (cw.bsel)
      B_SHIFT:     ectl.data = SC_SHIFT;
      B_EXT:       ectl.data = SC_EXT;
      B_BREAK:     ectl.data = SC_BREAK;
      B_SLOT_CODE: ectl.data = code_slot;
      B_SCAN_CODE: ectl.data = code_scan;
      default:     ectl.data = 8'h00;
    endcase
  end

  assign go = !hold;

  hkps_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ectl),
    .out_stall    (out_stall),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_scancode (out_scancode),
    .out_last     (out_last)
  );

  // step sequencing
  always_comb begin
    step_nxt = step_r;
    case (cw.kind)
      K_IDLE: begin
        if (in_acc && in_op) step_nxt = cw.nxt;
      end
      K_CLEAR: begin
        if (scan_last) step_nxt = cw.alt;
      end
      K_SLOT_RD: begin
        if (key != 8'd0) step_nxt = cw.nxt;
        else if (slot_last) step_nxt = cw.alt;
      end
      K_EMIT: begin
        if (go) begin
          if (cw.adv_slot) step_nxt = slot_last ? cw.alt : cw.nxt;
          else if (cw.adv_scan) step_nxt = scan_last ? cw.alt : cw.nxt;
          else step_nxt = cw.nxt;
        end
      end
      K_SCAN_RD: begin
        step_nxt = cw.nxt;
      end
      K_SCAN_TEST: begin
        if (release_k) step_nxt = cw.nxt;
        else if (scan_last) step_nxt = cw.alt;
      end
      K_FLUSH: begin
        if (go) step_nxt = cw.nxt;
      end
      default: step_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    logic [7:0] k;
    held_nxt       = held_r;
    shift_down_nxt = shift_down_r;
    make_sent_nxt  = make_sent_r;
    slot_nxt       = slot_r;
    j_nxt          = j_r;
    rd_en          = 1'b0;
    rd_addr        = j_r;
    wr_en          = 1'b0;
    wr_addr        = j_r;
    wr_data        = 8'd0;
    k              = 8'd0;
    case (cw.kind)
      K_IDLE: begin
        if (in_acc && !in_op) begin
          if (in_report_length != 4'd0) begin
            shift_down_nxt = (in_byte0 & MOD_SHIFT_MASK) != 8'd0;
          end
          for (int s = 0; s < KEY_SLOTS; s++) begin
            k = (in_report_length < 4'd8) ? rpt[3'(s + 1)] : rpt[3'(s + 2)];
            held_nxt[s] = (({1'b0, k} < 9'(KEY_CODES)) && (set2_map(k) != 8'd0)) ?
                          k : 8'd0;
          end
        end else if (in_acc) begin
          slot_nxt = '0;
          j_nxt    = '0;
        end
      end
      K_CLEAR: begin
        wr_en = 1'b1;
        j_nxt = scan_last ? '0 : j_r + CW'(1);
      end
      K_SLOT_RD: begin
        if (key != 8'd0) begin
          rd_en   = 1'b1;
          rd_addr = key[CW-1:0];
        end else if (!slot_last) begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      K_EMIT: begin
        if (go) begin
          if (cw.wr_inc) begin
            wr_en   = 1'b1;
            wr_addr = key[CW-1:0];
            wr_data = cnt + 8'd1;
          end
          if (cw.wr_zero) wr_en = 1'b1;
          if (cw.set_make && cond_ok) make_sent_nxt = 1'b1;
          if (cw.clr_make && cond_ok) make_sent_nxt = 1'b0;
          if (cw.adv_slot && !slot_last) slot_nxt = slot_r + SW'(1);
          if (cw.adv_scan && !scan_last) j_nxt = j_r + CW'(1);
        end
      end
      K_SCAN_RD: begin
        rd_en = 1'b1;
      end
      K_SCAN_TEST: begin
        // read the next counter while testing this one
        if (!release_k && !scan_last) begin
          j_nxt   = j_r + CW'(1);
          rd_en   = 1'b1;
          rd_addr = j_r + CW'(1);
        end
      end
      K_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_CLEAR;
      shift_down_r <= 1'b0;
      make_sent_r  <= 1'b0;
      slot_r       <= '0;
      j_r          <= '0;
      for (int s = 0; s < KEY_SLOTS; s++) held_r[s] <= 8'd0;
    end else begin
      step_r       <= step_nxt;
      shift_down_r <= shift_down_nxt;
      make_sent_r  <= make_sent_nxt;
      slot_r       <= slot_nxt;
      j_r          <= j_nxt;
      held_r       <= held_nxt;
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= 8'd20;
      ivl_r   <= 3'd2;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_REPEAT_DELAY: delay_r <= pwdata[7:0];
        REG_REPEAT_IVL:   ivl_r   <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_REPEAT_DELAY: prdata = {24'd0, delay_r};
      REG_REPEAT_IVL:   prdata = {29'd0, ivl_r};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/hkps_checker.sv
// Port-level checks for the HID to PS/2 scancode unit, bound to the top level.
// Sees only the top-level ports; no package needed.
module hkps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_scancode,
  input logic       out_last
);

  // the clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during the clearing pass");

  // a tick starts the sequencer, so the next cycle must stall input
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op) |=> in_stall)
    else $error("tick transfer did not start the sequencer");

  // a report completes in its own cycle
  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_op) |=> !in_stall)
    else $error("report transfer left the block busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_scancode) && $stable(out_last)))
    else $error("stalled output changed");

endmodule

bind hid_keys_to_ps2_scancodes_unit hkps_checker u_hkps_checker (.*);
